@@ hdl/stss_pkg.sv @@
package stss_pkg;

    // field and entry widths
    localparam int unsigned WHOLE_W  = 22;
    localparam int unsigned ENTRY_W  = 24;
    localparam int unsigned MAX_RESULTS = 3;

    // register defaults and limits
    localparam logic [21:0] WHOLE_RESET = 22'd96000;
    localparam logic [21:0] WHOLE_MIN   = 22'd64;
    localparam logic [3:0]  BARS_RESET  = 4'd1;
    localparam logic [8:0]  DUR_MAX     = 9'd256;
    localparam logic [3:0]  STEPS_CAP   = 4'd8;

    // step entry: duration[23:15] play[14] velocity[13:7] pitch[6:0]
    localparam logic [23:0] ENTRY_RESET = {9'd128, 1'b1, 7'd100, 7'd48};

    // position wrap points
    localparam logic [6:0] QUARTER_TOP = 7'd4;
    localparam logic [6:0] EIGHTH_TOP  = 7'd8;
    localparam logic [6:0] X16_TOP     = 7'd16;
    localparam logic [6:0] X32_TOP     = 7'd32;
    localparam logic [6:0] X64_TOP     = 7'd64;

    // request codes
    typedef logic [2:0] t_req;
    localparam t_req REQ_TICK  = 3'd0;
    localparam t_req REQ_PLAY  = 3'd1;
    localparam t_req REQ_STOP  = 3'd2;
    localparam t_req REQ_PAUSE = 3'd3;
    localparam t_req REQ_LOAD  = 3'd4;

    // event kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_STATUS = 2'd0;
    localparam t_kind KIND_ON     = 2'd1;
    localparam t_kind KIND_OFF    = 2'd2;
    localparam t_kind KIND_ALLOFF = 2'd3;

    // register index (paddr bit 2)
    localparam logic REG_WHOLE = 1'b0;
    localparam logic REG_BARS  = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_PAUSED  = 2'd2
    } t_mode;

    // position counter increment, counts 1..top
    function automatic logic [6:0] bump_pos(input logic [6:0] v, input logic [6:0] top);
        logic [6:0] v1;
        v1 = v + 7'd1;
        return (v1 > top) ? 7'd1 : v1;
    endfunction

endpackage

@@ hdl/stss_in_if.sv @@
interface stss_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [2:0] bar_index;
    logic [2:0] step_index;
    logic [6:0] pitch_in;
    logic [6:0] velocity_in;
    logic       play_flag;
    logic [8:0] duration_in;

    modport source (output valid, req_type, bar_index, step_index, pitch_in,
                    velocity_in, play_flag, duration_in, input ready);
    modport sink   (input valid, req_type, bar_index, step_index, pitch_in,
                    velocity_in, play_flag, duration_in, output ready);
endinterface

@@ hdl/stss_out_if.sv @@
interface stss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [6:0]  event_pitch;
    logic [6:0]  event_velocity;
    logic [15:0] bars_elapsed;
    logic [2:0]  quarter_out;
    logic [3:0]  eighth_out;
    logic [4:0]  sixteenth_out;
    logic [5:0]  thirty_second_out;
    logic [6:0]  sixty_fourth_out;
    logic [2:0]  seq_bar_out;
    logic [2:0]  seq_step_out;
    logic        last;

    modport source (output valid, event_kind, event_pitch, event_velocity, bars_elapsed,
                    quarter_out, eighth_out, sixteenth_out, thirty_second_out,
                    sixty_fourth_out, seq_bar_out, seq_step_out, last, input ready);
    modport sink   (input valid, event_kind, event_pitch, event_velocity, bars_elapsed,
                    quarter_out, eighth_out, sixteenth_out, thirty_second_out,
                    sixty_fourth_out, seq_bar_out, seq_step_out, last, output ready);
endinterface

@@ hdl/stss_ram.sv @@
module stss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/sample_tick_step_sequencer.sv @@
// Channel     Dir  Beat
// i_in        in   one request: tick, play, stop, pause or step load
// o_out       out  one event, last set on the final event of a request
// APB         in   whole_note_samples at 0x0, num_bars at 0x4
//
// A tick while playing runs step-length division (S_LEN), remainder lanes
// (S_MOD: seven divisors in parallel, one count bit a cycle), table read, note
// insert and event scan (S_FIRE, S_NOTE, S_MASK), one event per cycle while the
// output accepts, then a retire step. Other requests go straight to output.
// Reset is synchronous; the step table reads as its default until loaded, by
// per-entry valid flags, with no clearing pass. Events wait in one output stage.
module sample_tick_step_sequencer
    import stss_pkg::*;
#(
    parameter int MAX_BARS      = 8,
    parameter int PENDING_NOTES = 2,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stss_in_if.sink     i_in,
    stss_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TBL_DEPTH = MAX_BARS * 8;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int BAR_W     = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int SLOT_W    = $clog2(PENDING_NOTES);
    localparam int EV_N      = 2 * PENDING_NOTES;
    localparam int EV_W      = $clog2(EV_N);
    localparam int CNT_W     = $clog2(COUNT_WIDTH);
    localparam int LANES     = 7;
    localparam int LEN_LANE  = 6;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LEN    = 7'b0000010,
        S_MOD    = 7'b0000100,
        S_FIRE   = 7'b0001000,
        S_NOTE   = 7'b0010000,
        S_MASK   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    // retire runs as a flag on the way back to idle
    t_state r_state;
    logic   r_retire;

    logic [21:0] r_whole;
    logic [3:0]  r_bars;
    t_mode       r_mode;

    logic [COUNT_WIDTH-1:0] r_s;
    logic [15:0] r_bar_cnt;
    logic [2:0]  r_q;
    logic [3:0]  r_e;
    logic [4:0]  r_x16;
    logic [5:0]  r_x32;
    logic [6:0]  r_x64;
    logic [BAR_W-1:0] r_cur_bar;
    logic [2:0]  r_cur_step;

    logic [TBL_DEPTH-1:0] r_tbl_vld;
    logic                 r_rd_def;

    logic [COUNT_WIDTH-1:0] r_p_start [PENDING_NOTES];
    logic [COUNT_WIDTH-1:0] r_p_end   [PENDING_NOTES];
    logic [13:0]            r_p_note  [PENDING_NOTES];
    logic [PENDING_NOTES-1:0] r_p_vld;

    logic [CNT_W-1:0] r_cnt;
    logic [22:0] r_lq;
    logic [3:0]  r_lrem;
    logic [21:0] r_rem [LANES];

    logic [30:0] r_prod;
    logic [13:0] r_note;
    logic        r_fire_play;

    logic [EV_N-1:0] r_ev_mask;
    logic [1:0]      r_emit_cnt;
    t_kind           r_solo_kind;
    logic            r_is_tick;

    logic        r_ov;
    t_kind       r_o_kind;
    logic [6:0]  r_o_pitch;
    logic [6:0]  r_o_vel;
    logic [15:0] r_o_bars;
    logic [2:0]  r_o_q;
    logic [3:0]  r_o_e;
    logic [4:0]  r_o_x16;
    logic [5:0]  r_o_x32;
    logic [6:0]  r_o_x64;
    logic [2:0]  r_o_sbar;
    logic [2:0]  r_o_sstep;
    logic        r_o_last;

    // handshakes
    logic in_acc, cfg_wr, out_load;
    assign i_in.ready = (r_state == S_IDLE) && !r_retire;
    assign in_acc     = i_in.valid && i_in.ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_BARS) ? {28'd0, r_bars} : {10'd0, r_whole};

    // divisors
    logic [21:0] w_eff;
    logic [22:0] w23;
    logic [21:0] div [LANES];
    logic [4:0]  bar_p1;
    logic [3:0]  steps;
    logic [22:0] len_num;

    always_comb begin
        w_eff   = (r_whole < WHOLE_MIN) ? WHOLE_MIN : r_whole;
        w23     = {1'b0, w_eff};
        div[0]  = w_eff;
        div[1]  = 22'((w23 + 23'd2)  >> 2);
        div[2]  = 22'((w23 + 23'd4)  >> 3);
        div[3]  = 22'((w23 + 23'd8)  >> 4);
        div[4]  = 22'((w23 + 23'd16) >> 5);
        div[5]  = 22'((w23 + 23'd32) >> 6);
        div[LEN_LANE] = r_lq[21:0];
        bar_p1  = 5'(r_cur_bar) + 5'd1;
        steps   = (bar_p1 > 5'(STEPS_CAP)) ? STEPS_CAP : 4'(bar_p1);
        len_num = w23 + 23'(steps >> 1);
    end

    // step length divider, one quotient bit a cycle
    logic [4:0] len_t;
    logic       len_ge;
    assign len_t  = {r_lrem, r_lq[22]};
    assign len_ge = len_t >= {1'b0, steps};

    // remainder lanes, one count bit a cycle
    logic [21:0] lane_nxt [LANES];
    logic        s_bit;
    assign s_bit = r_s[r_cnt];

    always_comb begin
        logic [22:0] t;
        for (int i = 0; i < LANES; i++) begin
            t = {r_rem[i], s_bit};
            lane_nxt[i] = (t >= {1'b0, div[i]}) ? 22'(t - {1'b0, div[i]}) : t[21:0];
        end
    end

    // step table
    logic [TBL_AW-1:0] rd_addr, wr_addr;
    logic              tbl_we, load_ok;
    logic [23:0]       tbl_wdata, tbl_rdata, entry;
    logic [8:0]        load_dur, ent_dur;

    assign rd_addr   = TBL_AW'({r_cur_bar, r_cur_step});
    assign wr_addr   = TBL_AW'({i_in.bar_index, i_in.step_index});
    assign load_ok   = 5'(i_in.bar_index) < 5'(MAX_BARS);
    assign load_dur  = (i_in.duration_in > DUR_MAX) ? DUR_MAX : i_in.duration_in;
    assign tbl_we    = in_acc && (i_in.req_type == REQ_LOAD) && load_ok;
    assign tbl_wdata = {load_dur, i_in.play_flag, i_in.velocity_in, i_in.pitch_in};
    assign entry     = r_rd_def ? ENTRY_RESET : tbl_rdata;
    assign ent_dur   = (entry[23:15] > DUR_MAX) ? DUR_MAX : entry[23:15];

    stss_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (wr_addr),
        .i_wdata (tbl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (tbl_rdata)
    );

    // sequence advance
    logic [4:0] nb, bar_nx;
    logic [3:0] step_nx;
    always_comb begin
        if (r_bars == 4'd0) begin
            nb = 5'd1;
        end else if (5'(r_bars) > 5'(MAX_BARS)) begin
            nb = 5'(MAX_BARS);
        end else begin
            nb = 5'(r_bars);
        end
        bar_nx  = bar_p1;
        step_nx = 4'(r_cur_step) + 4'd1;
    end

    // note insert
    logic [23:0]            gate;
    logic [COUNT_WIDTH-1:0] note_end;
    logic                   ins_hit;
    logic [SLOT_W-1:0]      ins_slot;
    assign gate     = 24'(({1'b0, r_prod} + 32'd128) >> 8);
    assign note_end = r_s + COUNT_WIDTH'(gate);

    always_comb begin
        ins_hit  = 1'b0;
        ins_slot = '0;
        for (int k = 0; k < PENDING_NOTES; k++) begin
            if (!r_p_vld[k] && !ins_hit) begin
                ins_hit  = 1'b1;
                ins_slot = SLOT_W'(k);
            end
        end
    end

    // event scan: on and off per slot, oldest first
    logic [EV_N-1:0] ev_mask;
    always_comb begin
        for (int k = 0; k < PENDING_NOTES; k++) begin
            ev_mask[2*k]   = r_p_vld[k] && (r_s == r_p_start[k]);
            ev_mask[2*k+1] = r_p_vld[k] && (r_s == r_p_end[k]);
        end
    end

    // lowest pending event
    logic [EV_W-1:0]   pick;
    logic [EV_N-1:0]   mask_rest;
    logic [SLOT_W-1:0] pick_slot;
    logic              emit_last;
    always_comb begin
        pick = '0;
        for (int i = EV_N - 1; i >= 0; i--) begin
            if (r_ev_mask[i]) begin
                pick = EV_W'(i);
            end
        end
        mask_rest = r_ev_mask & ~(EV_N'(1) << pick);
        pick_slot = SLOT_W'(pick >> 1);
        emit_last = (mask_rest == '0) || (r_emit_cnt == 2'(MAX_RESULTS - 1));
    end

    // retire and compact, keeping age order
    logic [COUNT_WIDTH-1:0]   n_p_start [PENDING_NOTES];
    logic [COUNT_WIDTH-1:0]   n_p_end   [PENDING_NOTES];
    logic [13:0]              n_p_note  [PENDING_NOTES];
    logic [PENDING_NOTES-1:0] n_p_vld;
    always_comb begin
        logic [SLOT_W:0]        j;
        logic [COUNT_WIDTH-1:0] age, span;
        j = '0;
        for (int k = 0; k < PENDING_NOTES; k++) begin
            n_p_start[k] = r_p_start[k];
            n_p_end[k]   = r_p_end[k];
            n_p_note[k]  = r_p_note[k];
            n_p_vld[k]   = 1'b0;
        end
        for (int k = 0; k < PENDING_NOTES; k++) begin
            age  = r_s - r_p_start[k];
            span = r_p_end[k] - r_p_start[k];
            if (r_p_vld[k] && (age < span)) begin
                n_p_start[j[SLOT_W-1:0]] = r_p_start[k];
                n_p_end[j[SLOT_W-1:0]]   = r_p_end[k];
                n_p_note[j[SLOT_W-1:0]]  = r_p_note[k];
                n_p_vld[j[SLOT_W-1:0]]   = 1'b1;
                j = j + 1'b1;
            end
        end
    end

    assign out_load = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_retire   <= 1'b0;
            r_whole    <= WHOLE_RESET;
            r_bars     <= BARS_RESET;
            r_mode     <= MODE_STOPPED;
            r_s        <= '0;
            r_bar_cnt  <= '0;
            r_q        <= '0;
            r_e        <= '0;
            r_x16      <= '0;
            r_x32      <= '0;
            r_x64      <= '0;
            r_cur_bar  <= '0;
            r_cur_step <= '0;
            r_tbl_vld  <= '0;
            r_p_vld    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_BARS) begin
                    r_bars <= pwdata[3:0];
                end else begin
                    r_whole <= pwdata[21:0];
                end
            end

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (r_retire) begin
                        r_retire  <= 1'b0;
                        r_p_vld   <= n_p_vld;
                        r_s       <= r_s + COUNT_WIDTH'(1);
                    end else if (in_acc) begin
                        r_state <= S_EMIT;
                        case (i_in.req_type)
                            REQ_TICK: begin
                                if (r_mode == MODE_PLAYING) begin
                                    r_state <= S_LEN;
                                end
                            end
                            REQ_PLAY: r_mode <= MODE_PLAYING;
                            REQ_STOP: begin
                                r_mode    <= MODE_STOPPED;
                                r_s       <= '0;
                                r_bar_cnt <= '0;
                                r_q       <= '0;
                                r_e       <= '0;
                                r_x16     <= '0;
                                r_x32     <= '0;
                                r_x64     <= '0;
                                r_p_vld   <= '0;
                            end
                            REQ_PAUSE: r_mode <= MODE_PAUSED;
                            REQ_LOAD: begin
                                if (load_ok) begin
                                    r_tbl_vld[wr_addr] <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LEN: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIRE;
                    end
                end
                S_FIRE: begin
                    r_state <= S_NOTE;
                    if (r_rem[0] == '0) r_bar_cnt <= r_bar_cnt + 16'd1;
                    if (r_rem[1] == '0) r_q   <= 3'(bump_pos(7'(r_q), QUARTER_TOP));
                    if (r_rem[2] == '0) r_e   <= 4'(bump_pos(7'(r_e), EIGHTH_TOP));
                    if (r_rem[3] == '0) r_x16 <= 5'(bump_pos(7'(r_x16), X16_TOP));
                    if (r_rem[4] == '0) r_x32 <= 6'(bump_pos(7'(r_x32), X32_TOP));
                    if (r_rem[5] == '0) r_x64 <= bump_pos(r_x64, X64_TOP);
                    if (r_rem[LEN_LANE] == '0) begin
                        if (step_nx >= steps) begin
                            r_cur_step <= '0;
                            r_cur_bar  <= (bar_nx >= nb) ? '0 : BAR_W'(bar_nx);
                        end else begin
                            r_cur_step <= 3'(step_nx);
                        end
                    end
                end
                S_NOTE: begin
                    r_state <= S_MASK;
                    if (r_fire_play && ins_hit) begin
                        r_p_vld[ins_slot] <= 1'b1;
                    end
                end
                S_MASK: r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_load && ((r_ev_mask == '0) || emit_last)) begin
                        r_state  <= S_IDLE;
                        r_retire <= r_is_tick;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath and payload
    always_ff @(posedge i_clk) begin
        r_rd_def <= !r_tbl_vld[rd_addr];

        if (in_acc) begin
            r_ev_mask   <= '0;
            r_emit_cnt  <= '0;
            r_is_tick   <= (i_in.req_type == REQ_TICK) && (r_mode == MODE_PLAYING);
            r_solo_kind <= ((i_in.req_type == REQ_STOP) || (i_in.req_type == REQ_PAUSE))
                           ? KIND_ALLOFF : KIND_STATUS;
            r_lq        <= len_num;
            r_lrem      <= '0;
            r_cnt       <= CNT_W'(22);
        end

        if (r_state == S_LEN) begin
            r_lrem <= len_ge ? 4'(len_t - {1'b0, steps}) : len_t[3:0];
            r_lq   <= {r_lq[21:0], len_ge};
            if (r_cnt == '0) begin
                r_cnt <= CNT_W'(COUNT_WIDTH - 1);
                for (int i = 0; i < LANES; i++) r_rem[i] <= '0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end

        if (r_state == S_MOD) begin
            for (int i = 0; i < LANES; i++) r_rem[i] <= lane_nxt[i];
            r_cnt <= r_cnt - 1'b1;
        end

        if (r_state == S_FIRE) begin
            r_fire_play <= (r_rem[LEN_LANE] == '0) && entry[14];
            r_note      <= entry[13:0];
            r_prod      <= 31'(r_lq[21:0]) * 31'(ent_dur);
        end

        if ((r_state == S_NOTE) && r_fire_play && ins_hit) begin
            r_p_start[ins_slot] <= r_s;
            r_p_end[ins_slot]   <= note_end;
            r_p_note[ins_slot]  <= r_note;
        end

        if (r_state == S_MASK) begin
            r_ev_mask <= ev_mask;
        end

        if ((r_state == S_IDLE) && r_retire) begin
            r_p_start <= n_p_start;
            r_p_end   <= n_p_end;
            r_p_note  <= n_p_note;
        end

        // output beat
        if (out_load) begin
            r_o_bars  <= r_bar_cnt;
            r_o_q     <= r_q;
            r_o_e     <= r_e;
            r_o_x16   <= r_x16;
            r_o_x32   <= r_x32;
            r_o_x64   <= r_x64;
            r_o_sbar  <= 3'(r_cur_bar);
            r_o_sstep <= r_cur_step;
            if (r_ev_mask == '0) begin
                r_o_kind  <= r_solo_kind;
                r_o_pitch <= '0;
                r_o_vel   <= '0;
                r_o_last  <= 1'b1;
            end else begin
                r_o_kind   <= pick[0] ? KIND_OFF : KIND_ON;
                r_o_pitch  <= r_p_note[pick_slot][6:0];
                r_o_vel    <= r_p_note[pick_slot][13:7];
                r_o_last   <= emit_last;
                r_ev_mask  <= mask_rest;
                r_emit_cnt <= r_emit_cnt + 2'd1;
            end
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.event_kind        = r_o_kind;
    assign o_out.event_pitch       = r_o_pitch;
    assign o_out.event_velocity    = r_o_vel;
    assign o_out.bars_elapsed      = r_o_bars;
    assign o_out.quarter_out       = r_o_q;
    assign o_out.eighth_out        = r_o_e;
    assign o_out.sixteenth_out     = r_o_x16;
    assign o_out.thirty_second_out = r_o_x32;
    assign o_out.sixty_fourth_out  = r_o_x64;
    assign o_out.seq_bar_out       = r_o_sbar;
    assign o_out.seq_step_out      = r_o_sstep;
    assign o_out.last              = r_o_last;
endmodule

@@ dv/sample_tick_step_sequencer_check.sv @@
module sample_tick_step_sequencer_check
    import stss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    stss_in_if          i_in,
    stss_out_if         i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BARS_MAX = 8;
    localparam int SLOTS        = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [15:0] bars;
        logic [2:0]  q4;
        logic [3:0]  q8;
        logic [4:0]  q16;
        logic [5:0]  q32;
        logic [6:0]  q64;
        logic [2:0]  seq_bar;
        logic [2:0]  seq_step;
        logic        last;
    } event_t;

    event_t events_due[$];
    int     mismatches;

    // register copies
    logic [21:0] whole_reg;
    logic [3:0]  bars_reg;

    // transport and sequence state
    t_mode       mode;
    logic [31:0] samples;
    logic [15:0] bar_cnt;
    logic [6:0]  pos4, pos8, pos16, pos32, pos64;
    logic [2:0]  seq_bar, seq_step;
    logic [23:0] steps_tbl [64];
    logic [31:0] note_start [SLOTS];
    logic [31:0] note_end [SLOTS];
    logic [13:0] note_id [SLOTS];
    logic        note_live [SLOTS];

    assign o_errors      = mismatches;
    assign o_outstanding = events_due.size();

    function automatic logic [6:0] wrap_inc(input logic [6:0] v, input logic [6:0] top);
        return (v + 7'd1 > top) ? 7'd1 : v + 7'd1;
    endfunction

    function automatic event_t make_event(input logic [1:0] k, input logic [13:0] note);
        event_t e;
        e.kind = k;
        e.pitch = note[6:0];
        e.vel = note[13:7];
        e.bars = bar_cnt;
        e.q4 = pos4[2:0];
        e.q8 = pos8[3:0];
        e.q16 = pos16[4:0];
        e.q32 = pos32[5:0];
        e.q64 = pos64;
        e.seq_bar = seq_bar;
        e.seq_step = seq_step;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic clear_notes();
        for (int k = 0; k < SLOTS; k++) begin
            note_live[k] = 0;
            note_start[k] = 0;
            note_end[k] = 0;
            note_id[k] = 0;
        end
    endtask

    // one audio sample while playing
    task automatic advance_sample(ref event_t evs[$]);
        logic [31:0] s, w, steps, len, nb, dur, j;
        logic [63:0] gate;
        logic [23:0] ent;
        s = samples;
        w = (whole_reg < WHOLE_MIN) ? 32'(WHOLE_MIN) : 32'(whole_reg);
        nb = (bars_reg < 1) ? 1 : ((bars_reg > NUM_BARS_MAX) ? NUM_BARS_MAX : 32'(bars_reg));
        if (s % w == 0) bar_cnt = bar_cnt + 16'd1;
        if (s % ((w + 2) / 4) == 0) pos4 = wrap_inc(pos4, QUARTER_TOP);
        if (s % ((w + 4) / 8) == 0) pos8 = wrap_inc(pos8, EIGHTH_TOP);
        if (s % ((w + 8) / 16) == 0) pos16 = wrap_inc(pos16, X16_TOP);
        if (s % ((w + 16) / 32) == 0) pos32 = wrap_inc(pos32, X32_TOP);
        if (s % ((w + 32) / 64) == 0) pos64 = wrap_inc(pos64, X64_TOP);

        steps = 32'(seq_bar) + 1;
        if (steps > STEPS_CAP) steps = 32'(STEPS_CAP);
        len = (w + steps / 2) / steps;
        if (s % len == 0) begin
            ent = steps_tbl[{seq_bar, seq_step}];
            if (ent[14]) begin
                dur = 32'(ent[23:15]);
                if (dur > DUR_MAX) dur = 32'(DUR_MAX);
                gate = (64'(len) * dur + 128) >> 8;
                for (int k = 0; k < SLOTS; k++) begin
                    if (!note_live[k]) begin
                        note_live[k] = 1;
                        note_start[k] = s;
                        note_end[k] = s + gate[31:0];
                        note_id[k] = ent[13:0];
                        break;
                    end
                end
            end
            if (32'(seq_step) + 1 > steps - 1) begin
                seq_step = 0;
                seq_bar = (32'(seq_bar) + 1 > nb - 1) ? 3'd0 : seq_bar + 3'd1;
            end else begin
                seq_step = seq_step + 3'd1;
            end
        end

        // note events, oldest first, capped at three
        for (int k = 0; k < SLOTS; k++) begin
            if (!note_live[k]) continue;
            if (s == note_start[k] && evs.size() < MAX_RESULTS)
                evs = {evs, make_event(KIND_ON, note_id[k])};
            if (s == note_end[k] && evs.size() < MAX_RESULTS)
                evs = {evs, make_event(KIND_OFF, note_id[k])};
        end

        // retire finished notes, compact the survivors
        j = 0;
        for (int k = 0; k < SLOTS; k++) begin
            if (!note_live[k]) continue;
            if (s - note_start[k] >= note_end[k] - note_start[k]) continue;
            note_start[j] = note_start[k];
            note_end[j] = note_end[k];
            note_id[j] = note_id[k];
            note_live[j] = 1;
            j++;
        end
        for (int k = int'(j); k < SLOTS; k++) begin
            note_live[k] = 0;
            note_start[k] = 0;
            note_end[k] = 0;
            note_id[k] = 0;
        end
        samples = s + 1;
    endtask

    task automatic predict_request();
        event_t evs[$];
        logic [8:0] dur;
        case (i_in.req_type)
            REQ_TICK: if (mode == MODE_PLAYING) advance_sample(evs);
            REQ_PLAY: mode = MODE_PLAYING;
            REQ_STOP: begin
                mode = MODE_STOPPED;
                samples = 0;
                bar_cnt = 0;
                {pos4, pos8, pos16, pos32, pos64} = '0;
                clear_notes();
                evs = {evs, make_event(KIND_ALLOFF, 14'd0)};
            end
            REQ_PAUSE: begin
                mode = MODE_PAUSED;
                evs = {evs, make_event(KIND_ALLOFF, 14'd0)};
            end
            REQ_LOAD: begin
                dur = (i_in.duration_in > DUR_MAX) ? DUR_MAX : i_in.duration_in;
                steps_tbl[{i_in.bar_index, i_in.step_index}] =
                    {dur, i_in.play_flag, i_in.velocity_in, i_in.pitch_in};
            end
            default: ;
        endcase
        if (evs.size() == 0) evs = {evs, make_event(KIND_STATUS, 14'd0)};
        evs[evs.size() - 1].last = 1'b1;
        events_due = {events_due, evs};
    endtask

    // watch config port, input and output beats
    always @(posedge i_clk) begin
        event_t got, exp_ev;
        if (!i_rst_n) begin
            whole_reg = WHOLE_RESET;
            bars_reg = BARS_RESET;
            mode = MODE_STOPPED;
            samples = 0;
            bar_cnt = 0;
            {pos4, pos8, pos16, pos32, pos64} = '0;
            seq_bar = 0;
            seq_step = 0;
            for (int i = 0; i < 64; i++) steps_tbl[i] = ENTRY_RESET;
            clear_notes();
            events_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[2] == REG_BARS) bars_reg = i_pwdata[3:0];
                else whole_reg = i_pwdata[21:0];
            end
            if (i_in.valid && i_in.ready) predict_request();
            if (i_out.valid && i_out.ready) begin
                got = {i_out.event_kind, i_out.event_pitch, i_out.event_velocity,
                       i_out.bars_elapsed, i_out.quarter_out, i_out.eighth_out,
                       i_out.sixteenth_out, i_out.thirty_second_out,
                       i_out.sixty_fourth_out, i_out.seq_bar_out, i_out.seq_step_out,
                       i_out.last};
                if (events_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected event beat: %h", got);
                end else begin
                    exp_ev = events_due.pop_front();
                    if (got !== exp_ev) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("event mismatch: expected %p, got %p", exp_ev, got);
                    end
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

@@ dv/sample_tick_step_sequencer_test.sv @@
module sample_tick_step_sequencer_test;
    import stss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_req REQ_SPARE = REQ_LOAD + 3'd1;
    localparam t_req REQ_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors, outstanding;
    int          send_idle, recv_idle;
    int          hold_token, hold_seen, hold_left;
    int          sent_items;

    stss_in_if  req_ch ();
    stss_out_if evt_ch ();

    sample_tick_step_sequencer uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(req_ch.sink), .o_out(evt_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sample_tick_step_sequencer_check checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(req_ch), .i_out(evt_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_errors(errors), .o_outstanding(outstanding)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("[sample_tick_step_sequencer] ERROR");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        hold_seen = 0;
        hold_left = 0;
        evt_ch.ready <= 0;
        forever begin
            @(posedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                evt_ch.ready <= 0;
            end else begin
                evt_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send(input t_req req, input logic [2:0] b, input logic [2:0] st,
                        input logic [6:0] p, input logic [6:0] v, input logic pf,
                        input logic [8:0] d);
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 0;
            @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= req;
        req_ch.bar_index <= b;
        req_ch.step_index <= st;
        req_ch.pitch_in <= p;
        req_ch.velocity_in <= v;
        req_ch.play_flag <= pf;
        req_ch.duration_in <= d;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_req(input t_req req);
        send(req, 3'($urandom), 3'($urandom), 7'($urandom), 7'($urandom), 1'($urandom),
             9'($urandom));
    endtask

    task automatic send_random();
        int pick;
        t_req req;
        pick = $urandom_range(99);
        if (pick < 74) req = REQ_TICK;
        else if (pick < 80) req = REQ_PLAY;
        else if (pick < 83) req = REQ_STOP;
        else if (pick < 86) req = REQ_PAUSE;
        else if (pick < 98) req = REQ_LOAD;
        else req = t_req'($urandom_range(REQ_LAST, REQ_SPARE));
        send_req(req);
    endtask

    task automatic drain(input int extra);
        req_ch.valid <= 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic run_phase(input logic [21:0] whole, input logic [3:0] bars, input int n);
        drain(150);
        reg_write(3'(REG_WHOLE) << 2, 32'(whole));
        reg_write(3'(REG_BARS) << 2, 32'(bars));
        send_req(REQ_PLAY);
        for (int i = 0; i < n; i++) begin
            // long receiver hold-off while ticks keep coming
            if (i == 20) hold_token++;
            // one pause of the sender until everything has drained
            if (i == n / 2) drain(0);
            send_random();
        end
    endtask

    initial begin
        rst_n <= 0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= 0;
        pwdata <= 0;
        req_ch.valid <= 0;
        req_ch.req_type <= REQ_TICK;
        req_ch.bar_index <= 0;
        req_ch.step_index <= 0;
        req_ch.pitch_in <= 0;
        req_ch.velocity_in <= 0;
        req_ch.play_flag <= 0;
        req_ch.duration_in <= 0;
        hold_token = 0;
        sent_items = 0;
        send_idle = 16;
        recv_idle = 48;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero gate, extremes of loads, unknown codes, transport control
        send(REQ_LOAD, 3'd0, 3'd0, 7'd127, 7'd127, 1'b1, 9'd0);
        send_req(REQ_TICK);
        send_req(REQ_PLAY);
        send_req(REQ_TICK);
        send_req(REQ_TICK);
        send_req(REQ_PLAY);
        send(REQ_LOAD, 3'd7, 3'd7, 7'd0, 7'd0, 1'b0, 9'd511);
        send(REQ_LOAD, 3'd0, 3'd1, 7'd1, 7'd64, 1'b1, 9'd256);
        send(REQ_LOAD, 3'd5, 3'd2, 7'd85, 7'd42, 1'b1, 9'd257);
        send(REQ_SPARE, 3'd7, 3'd7, 7'd127, 7'd127, 1'b1, 9'd511);
        send(REQ_LAST, 3'd0, 3'd0, 7'd0, 7'd0, 1'b0, 9'd0);
        send_req(REQ_PAUSE);
        send_req(REQ_TICK);
        send_req(REQ_PLAY);
        send_req(REQ_TICK);
        send_req(REQ_STOP);
        send_req(REQ_TICK);
        send_req(REQ_PAUSE);
        send_req(REQ_STOP);

        // random phases across register settings
        run_phase(22'd64, 4'd8, 25);
        send_idle = 48;
        recv_idle = 16;
        run_phase(22'd10, 4'd0, 12);
        run_phase(22'd4194303, 4'd15, 6);
        send_idle = 0;
        recv_idle = 0;
        run_phase(22'd100, 4'd3, 25);
        run_phase(22'd200, 4'd1, 10);
        drain(200);

        $display("Ran %0d requests over five tempo and bar-count settings,", sent_items);
        $display("with zero gates, note overlap, pause/stop and receiver hold-offs.");
        if (errors == 0 && outstanding == 0) begin
            $display("[sample_tick_step_sequencer] OK");
        end else begin
            $display("[sample_tick_step_sequencer] ERROR");
        end
        $finish;
    end

endmodule
